/* src/lu_pkg.sv */
// Package for the LU linear solver: sizes, types, state codes and
// fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
package lu_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_BITS   = $clog2(MAX_ORDER);
    localparam int CNT_BITS   = $clog2(MAX_ORDER + 1);
    localparam int ADDR_BITS  = 2 * IDX_BITS;
    localparam int FIELD_BITS = 4;
    localparam int SIZE_BITS  = 5;
    localparam int DIV_BITS   = WORD_BITS + FRAC_BITS;
    localparam int SAT_BITS   = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        mag_t;
    typedef logic [SAT_BITS-1:0]         wide_t;

    typedef enum logic [0:0] {
        CFG_SIZE  = 1'b0,
        CFG_PIVOT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_U,
        PH_L,
        PH_F,
        PH_B
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CP_RD,
        S_CP_WR,
        S_PV_RD,
        S_PV_CMP,
        S_SW_RD1,
        S_SW_RD2,
        S_SW_WR1,
        S_SW_WR2,
        S_DOT_INIT,
        S_RDA,
        S_RDB,
        S_MUL,
        S_ACC,
        S_BASE_RD,
        S_DIFF,
        S_DIV,
        S_WB,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } state_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic mag_t mag_of(word_t a);
        mag_of = a[WORD_BITS-1] ? mag_t'(-a) : mag_t'(a);
    endfunction

    function automatic word_t sat_mag(logic neg, wide_t m);
        wide_t lim;
        lim = SAT_BITS'(WMAX) + SAT_BITS'(neg);
        if (m > lim) begin
            sat_mag = neg ? WMIN : WMAX;
        end else if (neg) begin
            sat_mag = word_t'(-m[WORD_BITS-1:0]);
        end else begin
            sat_mag = word_t'(m[WORD_BITS-1:0]);
        end
    endfunction

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            sat_add = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            sat_add = word_t'(s[WORD_BITS-1:0]);
        end
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            sat_sub = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            sat_sub = word_t'(s[WORD_BITS-1:0]);
        end
    endfunction

    function automatic word_t fx_mul(word_t a, word_t b);
        wide_t p;
        p = SAT_BITS'(mag_of(a)) * SAT_BITS'(mag_of(b));
        fx_mul = sat_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1], p >> FRAC_BITS);
    endfunction

endpackage

/* src/lu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/lu_div.sv */
// Iterative fixed-point divider, one quotient bit per cycle, saturating.
// Depends on lu_pkg.
`timescale 1ns / 1ps
module lu_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  lu_pkg::word_t num,
    input  lu_pkg::word_t den,
    output logic          done,
    output lu_pkg::word_t quo
);
    import lu_pkg::*;

    localparam int CB = $clog2(DIV_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CB-1:0]       cnt_reg, cnt_next;
    mag_t                rem_reg, rem_next;
    logic [DIV_BITS-1:0] sh_reg, sh_next;
    mag_t                den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [WORD_BITS:0]  rem_sh;
    logic                ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg, sh_reg[DIV_BITS-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CB'(DIV_BITS);
            rem_next  = '0;
            sh_next   = {mag_of(num), {FRAC_BITS{1'b0}}};
            den_next  = mag_of(den);
            neg_next  = num[WORD_BITS-1] ^ den[WORD_BITS-1];
        end else if (busy_reg) begin
            rem_next = ge ? mag_t'(rem_sh - {1'b0, den_reg}) : mag_t'(rem_sh);
            sh_next  = {sh_reg[DIV_BITS-2:0], ge};
            cnt_next = cnt_reg - CB'(1);
            if (cnt_reg == CB'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = sat_mag(neg_reg, SAT_BITS'(sh_reg));

endmodule

/* src/lu_linear_solver.sv */
// Top level of the LU linear solver: load port, sequencer and memories.
// Depends on lu_pkg, lu_ram and lu_div.
`timescale 1ns / 1ps
// Load beats are taken one per cycle. The beat with last_load set starts a
// solve; no input is taken until its n result beats have gone out. A solve
// copies A and b into a work memory, optionally reorders rows (a column scan
// and, where needed, a row swap), then factors in place and substitutes. Each
// multiply-accumulate term steps through the states RDA, RDB, MUL and ACC on
// the single read port of the work memory, and each division runs in the
// serial divider. Results then leave one beat at a time, and the next beat is
// read only after m_ready has taken the last.
module lu_linear_solver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [lu_pkg::SIZE_BITS-1:0]    cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [lu_pkg::FIELD_BITS-1:0]   s_row_index,
    input  logic [lu_pkg::FIELD_BITS-1:0]   s_col_index,
    input  lu_pkg::word_t                   s_value,
    input  logic                            s_last_load,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lu_pkg::FIELD_BITS-1:0]   m_solution_index,
    output lu_pkg::word_t                   m_solution_value,
    output logic                            m_singular,
    output logic                            m_last_result
);
    import lu_pkg::*;

    localparam int MDEPTH = MAX_ORDER * MAX_ORDER;

    state_t                state_reg, state_next;
    phase_t                ph_reg, ph_next;
    logic [SIZE_BITS-1:0]  size_reg;
    logic                  pen_reg;
    logic [CNT_BITS-1:0]   n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_BITS-1:0]   k_reg, k_next, best_reg, best_next;
    logic                  selv_reg, selv_next, sing_reg, sing_next;
    word_t                 mx_reg, mx_next, t_reg, t_next, acc_reg, acc_next;
    word_t                 opa_reg, opa_next, prod_reg, prod_next;
    word_t                 res_reg, res_next, piv_reg, piv_next;
    logic                  mv_reg, mv_next, ml_reg, ml_next, ms_reg, ms_next;
    logic [FIELD_BITS-1:0] mi_reg, mi_next;
    word_t                 mval_reg, mval_next;

    logic                  a_we, b_we, w_we, v_we;
    logic [ADDR_BITS-1:0]  a_waddr, a_raddr, w_waddr, w_raddr;
    logic [IDX_BITS-1:0]   b_waddr, b_raddr, v_waddr, v_raddr;
    word_t                 w_wdata, v_wdata, a_rd, b_rd, w_rd, v_rd;
    logic                  div_start, div_done;
    word_t                 div_den, div_quo, diff, op_b, sw_rd;
    logic [CNT_BITS-1:0]   kstart, kend, arow, n_clamp, best_new;
    logic                  vec_ph, col_done, fact_start;

    function automatic logic [ADDR_BITS-1:0] wa(logic [CNT_BITS-1:0] r,
                                                 logic [CNT_BITS-1:0] c);
        wa = {r[IDX_BITS-1:0], c[IDX_BITS-1:0]};
    endfunction

    lu_ram #(.WIDTH(WORD_BITS), .DEPTH(MDEPTH)) u_a_ram (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(s_value),
        .raddr(a_raddr), .rdata(a_rd));
    lu_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ORDER)) u_b_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(s_value),
        .raddr(b_raddr), .rdata(b_rd));
    lu_ram #(.WIDTH(WORD_BITS), .DEPTH(MDEPTH)) u_w_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rd));
    lu_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_ORDER)) u_v_ram (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rd));

    lu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(diff),
        .den(div_den), .done(div_done), .quo(div_quo));

    assign vec_ph = (ph_reg == PH_F) || (ph_reg == PH_B);
    assign kstart = (ph_reg == PH_B) ? CNT_BITS'(i_reg + 1'b1) : '0;
    assign kend   = (ph_reg == PH_B) ? n_reg : i_reg;
    assign arow   = (ph_reg == PH_L) ? j_reg : i_reg;
    assign op_b   = vec_ph ? v_rd : w_rd;
    assign sw_rd  = selv_reg ? v_rd : w_rd;
    assign diff   = sat_sub(op_b, acc_reg);
    assign n_clamp = (size_reg == '0) ? CNT_BITS'(1) :
                     (int'(size_reg) > MAX_ORDER) ? CNT_BITS'(MAX_ORDER) :
                     CNT_BITS'(size_reg);
    assign best_new = ((i_reg == k_reg) || (w_rd > mx_reg)) ? i_reg : best_reg;

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        best_next  = best_reg;
        selv_next  = selv_reg;
        sing_next  = sing_reg;
        mx_next    = mx_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        piv_next   = piv_reg;
        mv_next    = mv_reg;
        ml_next    = ml_reg;
        ms_next    = ms_reg;
        mi_next    = mi_reg;
        mval_next  = mval_reg;
        div_start  = 1'b0;
        div_den    = piv_reg;
        col_done   = 1'b0;
        fact_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_last_load) begin
                    n_next     = n_clamp;
                    i_next     = '0;
                    j_next     = '0;
                    sing_next  = 1'b0;
                    state_next = S_CP_RD;
                end
            end
            S_CP_RD: state_next = S_CP_WR;
            S_CP_WR: begin
                state_next = S_CP_RD;
                if (CNT_BITS'(j_reg + 1'b1) < n_reg) begin
                    j_next = CNT_BITS'(j_reg + 1'b1);
                end else if (CNT_BITS'(i_reg + 1'b1) < n_reg) begin
                    i_next = CNT_BITS'(i_reg + 1'b1);
                    j_next = '0;
                end else if (pen_reg) begin
                    k_next     = '0;
                    i_next     = '0;
                    state_next = S_PV_RD;
                end else begin
                    fact_start = 1'b1;
                end
            end
            S_PV_RD: state_next = S_PV_CMP;
            S_PV_CMP: begin
                best_next = best_new;
                if (best_new == i_reg) begin
                    mx_next = w_rd;
                end
                if (CNT_BITS'(i_reg + 1'b1) < n_reg) begin
                    i_next     = CNT_BITS'(i_reg + 1'b1);
                    state_next = S_PV_RD;
                end else if (best_new != k_reg) begin
                    j_next     = '0;
                    selv_next  = 1'b0;
                    state_next = S_SW_RD1;
                end else begin
                    col_done = 1'b1;
                end
            end
            S_SW_RD1: state_next = S_SW_RD2;
            S_SW_RD2: begin
                t_next     = sw_rd;
                state_next = S_SW_WR1;
            end
            S_SW_WR1: state_next = S_SW_WR2;
            S_SW_WR2: begin
                state_next = S_SW_RD1;
                if (selv_reg) begin
                    col_done = 1'b1;
                end else if (CNT_BITS'(j_reg + 1'b1) < n_reg) begin
                    j_next = CNT_BITS'(j_reg + 1'b1);
                end else begin
                    selv_next = 1'b1;
                end
            end
            S_DOT_INIT: begin
                acc_next   = '0;
                k_next     = kstart;
                state_next = (kstart == kend) ? S_BASE_RD : S_RDA;
            end
            S_RDA: state_next = S_RDB;
            S_RDB: begin
                opa_next   = w_rd;
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = fx_mul(opa_reg, op_b);
                state_next = S_ACC;
            end
            S_ACC: begin
                acc_next   = sat_add(acc_reg, prod_reg);
                k_next     = CNT_BITS'(k_reg + 1'b1);
                state_next = (CNT_BITS'(k_reg + 1'b1) == kend) ? S_BASE_RD : S_RDA;
            end
            S_BASE_RD: state_next = S_DIFF;
            S_DIFF: begin
                if (ph_reg == PH_L) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else if (ph_reg == PH_B) begin
                    div_start  = 1'b1;
                    div_den    = w_rd;
                    state_next = S_DIV;
                end else begin
                    res_next   = diff;
                    state_next = S_WB;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_quo;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                state_next = S_DOT_INIT;
                case (ph_reg)
                    PH_U: begin
                        if (j_reg == i_reg && res_reg == '0) begin
                            sing_next  = 1'b1;
                            i_next     = '0;
                            state_next = S_EM_RD;
                        end else begin
                            if (j_reg == i_reg) begin
                                piv_next = res_reg;
                            end
                            if (CNT_BITS'(j_reg + 1'b1) < n_reg) begin
                                j_next = CNT_BITS'(j_reg + 1'b1);
                            end else if (CNT_BITS'(i_reg + 1'b1) < n_reg) begin
                                ph_next = PH_L;
                                j_next  = CNT_BITS'(i_reg + 1'b1);
                            end else begin
                                ph_next = PH_F;
                                i_next  = '0;
                            end
                        end
                    end
                    PH_L: begin
                        if (CNT_BITS'(j_reg + 1'b1) < n_reg) begin
                            j_next = CNT_BITS'(j_reg + 1'b1);
                        end else begin
                            ph_next = PH_U;
                            i_next  = CNT_BITS'(i_reg + 1'b1);
                            j_next  = CNT_BITS'(i_reg + 1'b1);
                        end
                    end
                    PH_F: begin
                        if (CNT_BITS'(i_reg + 1'b1) < n_reg) begin
                            i_next = CNT_BITS'(i_reg + 1'b1);
                        end else begin
                            ph_next = PH_B;
                            i_next  = CNT_BITS'(n_reg - 1'b1);
                        end
                    end
                    default: begin
                        if (i_reg == '0) begin
                            state_next = S_EM_RD;
                        end else begin
                            i_next = CNT_BITS'(i_reg - 1'b1);
                        end
                    end
                endcase
            end
            S_EM_RD: state_next = S_EM_LD;
            S_EM_LD: begin
                mv_next    = 1'b1;
                mi_next    = FIELD_BITS'(i_reg[IDX_BITS-1:0]);
                mval_next  = sing_reg ? '0 : v_rd;
                ms_next    = sing_reg;
                ml_next    = (CNT_BITS'(i_reg + 1'b1) == n_reg);
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (ml_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = CNT_BITS'(i_reg + 1'b1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (col_done) begin
            if (CNT_BITS'(k_reg + 1'b1) < n_reg) begin
                k_next     = CNT_BITS'(k_reg + 1'b1);
                i_next     = CNT_BITS'(k_reg + 1'b1);
                state_next = S_PV_RD;
            end else begin
                fact_start = 1'b1;
            end
        end
        if (fact_start) begin
            ph_next    = PH_U;
            i_next     = '0;
            j_next     = '0;
            state_next = S_DOT_INIT;
        end
    end

    // memory and port controls
    always_comb begin
        s_ready = (state_reg == S_IDLE);
        a_we    = s_valid && s_ready && !s_req_type &&
                  int'(s_row_index) < MAX_ORDER && int'(s_col_index) < MAX_ORDER;
        b_we    = s_valid && s_ready && s_req_type && int'(s_row_index) < MAX_ORDER;
        a_waddr = {IDX_BITS'(s_row_index), IDX_BITS'(s_col_index)};
        b_waddr = IDX_BITS'(s_row_index);
        a_raddr = wa(i_reg, j_reg);
        b_raddr = i_reg[IDX_BITS-1:0];
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = res_reg;
        w_raddr = '0;
        v_we    = 1'b0;
        v_waddr = '0;
        v_wdata = res_reg;
        v_raddr = '0;
        case (state_reg)
            S_CP_WR: begin
                w_we    = 1'b1;
                w_waddr = wa(i_reg, j_reg);
                w_wdata = a_rd;
                v_we    = (j_reg == '0);
                v_waddr = i_reg[IDX_BITS-1:0];
                v_wdata = b_rd;
            end
            S_PV_RD: w_raddr = wa(i_reg, k_reg);
            S_SW_RD1: begin
                w_raddr = wa(k_reg, j_reg);
                v_raddr = k_reg[IDX_BITS-1:0];
            end
            S_SW_RD2: begin
                w_raddr = wa(best_reg, j_reg);
                v_raddr = best_reg[IDX_BITS-1:0];
            end
            S_SW_WR1: begin
                w_we    = !selv_reg;
                v_we    = selv_reg;
                w_waddr = wa(k_reg, j_reg);
                v_waddr = k_reg[IDX_BITS-1:0];
                w_wdata = sw_rd;
                v_wdata = sw_rd;
            end
            S_SW_WR2: begin
                w_we    = !selv_reg;
                v_we    = selv_reg;
                w_waddr = wa(best_reg, j_reg);
                v_waddr = best_reg[IDX_BITS-1:0];
                w_wdata = t_reg;
                v_wdata = t_reg;
            end
            S_RDA: w_raddr = wa(arow, k_reg);
            S_RDB: begin
                w_raddr = (ph_reg == PH_U) ? wa(k_reg, j_reg) : wa(k_reg, i_reg);
                v_raddr = k_reg[IDX_BITS-1:0];
            end
            S_BASE_RD: begin
                case (ph_reg)
                    PH_U:    w_raddr = wa(i_reg, j_reg);
                    PH_L:    w_raddr = wa(j_reg, i_reg);
                    default: w_raddr = wa(i_reg, i_reg);
                endcase
                v_raddr = i_reg[IDX_BITS-1:0];
            end
            S_WB: begin
                w_we    = !vec_ph;
                v_we    = vec_ph;
                w_waddr = (ph_reg == PH_L) ? wa(j_reg, i_reg) : wa(i_reg, j_reg);
                v_waddr = i_reg[IDX_BITS-1:0];
            end
            S_EM_RD: v_raddr = i_reg[IDX_BITS-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            size_reg  <= SIZE_BITS'(MAX_ORDER);
            pen_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SIZE:  size_reg <= cfg_data;
                    CFG_PIVOT: pen_reg  <= cfg_data[0];
                    default:   ;
                endcase
            end
        end
        ph_reg   <= ph_next;
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        best_reg <= best_next;
        selv_reg <= selv_next;
        sing_reg <= sing_next;
        mx_reg   <= mx_next;
        t_reg    <= t_next;
        acc_reg  <= acc_next;
        opa_reg  <= opa_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        piv_reg  <= piv_next;
        ml_reg   <= ml_next;
        ms_reg   <= ms_next;
        mi_reg   <= mi_next;
        mval_reg <= mval_next;
    end

    assign m_valid          = mv_reg;
    assign m_solution_index = mi_reg;
    assign m_solution_value = mval_reg;
    assign m_singular       = ms_reg;
    assign m_last_result    = ml_reg;

endmodule
